/* src/order_lifecycle_fill_tracker_macros.svh */
// assertion macros for the order lifecycle fill tracker
// used by the top level; expects clk and rst_n in the calling scope
`ifndef ORDER_LIFECYCLE_FILL_TRACKER_MACROS_SVH
`define ORDER_LIFECYCLE_FILL_TRACKER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define OLFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define OLFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/olft_pkg.sv */
// shared types and codes for the order lifecycle fill tracker
// no dependencies
package olft_pkg;

    localparam int SLOTS_DEFAULT = 256;

    // command codes
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_SUBMIT = 3'd1;
    localparam logic [2:0] OP_CANCEL = 3'd2;
    localparam logic [2:0] OP_REJECT = 3'd3;
    localparam logic [2:0] OP_EXPIRE = 3'd4;
    localparam logic [2:0] OP_FILL   = 3'd5;

    // order status codes
    localparam logic [2:0] ST_CREATED   = 3'd0;
    localparam logic [2:0] ST_SUBMITTED = 3'd1;
    localparam logic [2:0] ST_PARTIAL   = 3'd2;
    localparam logic [2:0] ST_FILLED    = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;
    localparam logic [2:0] ST_REJECTED  = 3'd5;
    localparam logic [2:0] ST_EXPIRED   = 3'd6;

    // error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_STATE    = 2'd1;
    localparam logic [1:0] ERR_ZERO     = 2'd2;
    localparam logic [1:0] ERR_OVERFILL = 2'd3;

    // one slot of the order table
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] total;
        logic [31:0] filled;
        logic [63:0] notional;
        logic [47:0] submit_time;
        logic [47:0] last_update;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/olft_ram.sv */
// generic single-clock ram, one write and one registered read port
// no dependencies
module olft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/olft_div.sv */
// restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle
// caller guarantees the quotient fits 32 bits (upper dividend half below divisor)
// no dependencies
module olft_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      quo_reg;
    logic [31:0]      dvs_reg;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        take;
    logic [31:0] rem_next;
    logic [31:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[31]};
        diff     = shifted - {1'b0, dvs_reg};
        take     = !diff[32];
        rem_next = take ? diff[31:0] : shifted[31:0];
        quo_next = {quo_reg[30:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[63:32];
            quo_reg <= dividend[31:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/order_lifecycle_fill_tracker.sv */
// order lifecycle fill tracker: top level, slot table in one ram, fsm, result register
// depends on olft_pkg, olft_ram, olft_div and order_lifecycle_fill_tracker_macros.svh
//
// usage
//   command channel: cmd_valid / cmd_stall with opcode, slot, amount, price, event_time;
//   an item is taken at a clock edge with cmd_valid high and cmd_stall low
//   result channel: res_valid / res_stall with slot_out, error_code, status_out,
//   filled_out, remaining_out, average_price_out, last_update_out; one result per item
//   steps: read, check, update, then the 32-step average-price divide when anything is
//   filled, then the load of the result register; no divide when the slot holds no fill
//   throughput: one item at a time; the 32-step divider and the read-modify-write of
//   the slot ram set its pace
//   reset: a clearing pass writes every slot to zero (status created) with cmd_stall
//   high; results are not valid during it
//   stall: a finished result waits in the output register while res_stall is high;
//   the next item may be taken and worked on meanwhile, and it waits in its last
//   state until the output register frees up
`include "order_lifecycle_fill_tracker_macros.svh"

module order_lifecycle_fill_tracker #(
    parameter int SLOTS = olft_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  opcode,
    input  logic [7:0]  slot,
    input  logic [31:0] amount,
    input  logic [31:0] price,
    input  logic [47:0] event_time,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  slot_out,
    output logic [1:0]  error_code,
    output logic [2:0]  status_out,
    output logic [31:0] filled_out,
    output logic [31:0] remaining_out,
    output logic [31:0] average_price_out,
    output logic [47:0] last_update_out
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RED_W = (IDX_W > 8) ? IDX_W : 8;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_UPDATE = 7'b0010000,
        S_DIVIDE = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // clearing pass
    logic [IDX_W-1:0] clr_reg;
    logic             clr_last;

    // latched command
    logic [2:0]       op_reg;
    logic [7:0]       slot_reg;
    logic [31:0]      amount_reg;
    logic [31:0]      price_reg;
    logic [47:0]      time_reg;
    logic [IDX_W-1:0] idx_reg;

    // slot index reduction
    logic [7:0]       red;
    logic [RED_W-1:0] red_ext;
    logic [IDX_W-1:0] idx_in;

    // check stage
    olft_pkg::entry_t rd_ent;
    olft_pkg::entry_t ent_reg;
    logic [31:0]      remaining;
    logic             active;
    logic [1:0]       err_chk;
    logic [1:0]       err_reg;
    logic             full_reg;
    logic [63:0]      prod_reg;

    // update stage
    olft_pkg::entry_t upd_ent;

    // ram port
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [olft_pkg::ENTRY_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [olft_pkg::ENTRY_W-1:0] ram_rdata;

    // divider
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quo;

    // pending result
    logic [1:0]  rs_err_reg;
    logic [2:0]  rs_status_reg;
    logic [31:0] rs_filled_reg;
    logic [31:0] rs_remaining_reg;
    logic [47:0] rs_last_reg;
    logic [31:0] avg_reg;

    // output register
    logic        res_valid_reg;
    logic        res_load;
    logic [7:0]  out_slot_reg;
    logic [1:0]  out_err_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_filled_reg;
    logic [31:0] out_remaining_reg;
    logic [31:0] out_avg_reg;
    logic [47:0] out_last_reg;

    // slot modulo SLOTS by binary conditional subtraction, eight narrow steps
    always_comb
    begin
        red = slot;
        for (int k = 7; k >= 0; k--)
        begin
            if (32'(red) >= (32'(SLOTS) << k))
            begin
                red = red - 8'(32'(SLOTS) << k);
            end
        end
        red_ext = RED_W'(red);
        idx_in  = red_ext[IDX_W-1:0];
    end

    assign clr_last  = (clr_reg == IDX_W'(SLOTS - 1));
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_load  = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);

    // command checks against the slot as read
    always_comb
    begin
        rd_ent    = olft_pkg::entry_t'(ram_rdata);
        remaining = rd_ent.total - rd_ent.filled;
        active    = rd_ent.status inside {olft_pkg::ST_SUBMITTED, olft_pkg::ST_PARTIAL};
        err_chk   = olft_pkg::ERR_OK;
        case (op_reg)
            olft_pkg::OP_CREATE:
            begin
                if (amount_reg == '0)
                begin
                    err_chk = olft_pkg::ERR_ZERO;
                end
            end
            olft_pkg::OP_SUBMIT:
            begin
                if (rd_ent.status != olft_pkg::ST_CREATED)
                begin
                    err_chk = olft_pkg::ERR_STATE;
                end
                else if (rd_ent.total == '0)
                begin
                    err_chk = olft_pkg::ERR_ZERO;
                end
            end
            olft_pkg::OP_CANCEL, olft_pkg::OP_EXPIRE:
            begin
                if (!active)
                begin
                    err_chk = olft_pkg::ERR_STATE;
                end
            end
            olft_pkg::OP_REJECT:
            begin
                if (!(rd_ent.status inside {olft_pkg::ST_CREATED, olft_pkg::ST_SUBMITTED}))
                begin
                    err_chk = olft_pkg::ERR_STATE;
                end
            end
            olft_pkg::OP_FILL:
            begin
                if (amount_reg == '0 || price_reg == '0)
                begin
                    err_chk = olft_pkg::ERR_ZERO;
                end
                else if (!active)
                begin
                    err_chk = olft_pkg::ERR_STATE;
                end
                else if (amount_reg > remaining)
                begin
                    err_chk = olft_pkg::ERR_OVERFILL;
                end
            end
            default:
            begin
                err_chk = olft_pkg::ERR_STATE;
            end
        endcase
    end

    // new slot contents; unchanged on any error
    always_comb
    begin
        upd_ent = ent_reg;
        if (err_reg == olft_pkg::ERR_OK)
        begin
            case (op_reg)
                olft_pkg::OP_CREATE:
                begin
                    upd_ent.status      = olft_pkg::ST_CREATED;
                    upd_ent.total       = amount_reg;
                    upd_ent.filled      = '0;
                    upd_ent.notional    = '0;
                    upd_ent.submit_time = '0;
                    upd_ent.last_update = time_reg;
                end
                olft_pkg::OP_SUBMIT:
                begin
                    upd_ent.status      = olft_pkg::ST_SUBMITTED;
                    upd_ent.submit_time = time_reg;
                    upd_ent.last_update = time_reg;
                end
                olft_pkg::OP_CANCEL:
                begin
                    upd_ent.status      = olft_pkg::ST_CANCELLED;
                    upd_ent.last_update = time_reg;
                end
                olft_pkg::OP_EXPIRE:
                begin
                    upd_ent.status      = olft_pkg::ST_EXPIRED;
                    upd_ent.last_update = time_reg;
                end
                olft_pkg::OP_REJECT:
                begin
                    upd_ent.status      = olft_pkg::ST_REJECTED;
                    upd_ent.last_update = time_reg;
                end
                olft_pkg::OP_FILL:
                begin
                    upd_ent.status      = full_reg ? olft_pkg::ST_FILLED
                                                   : olft_pkg::ST_PARTIAL;
                    upd_ent.filled      = ent_reg.filled + amount_reg;
                    upd_ent.notional    = ent_reg.notional + prod_reg;
                    upd_ent.last_update = time_reg;
                end
                default:
                begin
                    upd_ent = ent_reg;
                end
            endcase
        end
    end

    // ram access: clearing pass writes zeros, update stage writes back on success
    always_comb
    begin
        ram_re    = (state_reg == S_READ);
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = upd_ent;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_UPDATE && err_reg == olft_pkg::ERR_OK)
        begin
            ram_we = 1'b1;
        end
    end

    assign div_start = (state_reg == S_UPDATE) && (upd_ent.filled != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = div_start ? S_DIVIDE : S_DONE;
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR && !clr_last)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            op_reg     <= opcode;
            slot_reg   <= slot;
            amount_reg <= amount;
            price_reg  <= price;
            time_reg   <= event_time;
            idx_reg    <= idx_in;
        end
        if (state_reg == S_CHECK)
        begin
            ent_reg  <= rd_ent;
            err_reg  <= err_chk;
            full_reg <= (amount_reg == remaining);
            prod_reg <= 64'(amount_reg) * 64'(price_reg);
        end
        if (state_reg == S_UPDATE)
        begin
            rs_err_reg       <= err_reg;
            rs_status_reg    <= upd_ent.status;
            rs_filled_reg    <= upd_ent.filled;
            rs_remaining_reg <= upd_ent.total - upd_ent.filled;
            rs_last_reg      <= upd_ent.last_update;
            avg_reg          <= '0;
        end
        if (state_reg == S_DIVIDE && div_done)
        begin
            avg_reg <= div_quo;
        end
        if (res_load)
        begin
            out_slot_reg      <= slot_reg;
            out_err_reg       <= rs_err_reg;
            out_status_reg    <= rs_status_reg;
            out_filled_reg    <= rs_filled_reg;
            out_remaining_reg <= rs_remaining_reg;
            out_avg_reg       <= avg_reg;
            out_last_reg      <= rs_last_reg;
        end
    end

    olft_ram #(
        .WIDTH(olft_pkg::ENTRY_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    // average price = notional / filled
    olft_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(upd_ent.notional),
        .divisor (upd_ent.filled),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign res_valid         = res_valid_reg;
    assign slot_out          = out_slot_reg;
    assign error_code        = out_err_reg;
    assign status_out        = out_status_reg;
    assign filled_out        = out_filled_reg;
    assign remaining_out     = out_remaining_reg;
    assign average_price_out = out_avg_reg;
    assign last_update_out   = out_last_reg;

    // divider finishes only while the fsm waits for it
    `OLFT_ASSERT_NOW(a_div_done_in_divide, div_done, state_reg == S_DIVIDE,
        "divider finished outside the divide state")

    // slot ram written only by the clearing pass or a successful command
    `OLFT_ASSERT_NOW(a_ram_write_ok, ram_we,
        state_reg == S_CLEAR || (state_reg == S_UPDATE && err_reg == olft_pkg::ERR_OK),
        "slot ram written on an error or outside update")

    // a pending result never overwrites one still undelivered
    `OLFT_ASSERT_NOW(a_no_result_overwrite, res_valid_reg && res_stall,
        !res_load, "result register overwritten while stalled")

    // after a result is loaded the fsm is ready for the next item
    `OLFT_ASSERT_NEXT(a_load_then_idle, res_load, state_reg == S_IDLE && res_valid_reg,
        "result load did not return to idle")

endmodule

/* test/tb_order_lifecycle_fill_tracker.sv */
// testbench for order_lifecycle_fill_tracker: directed and random order commands, each result
// checked against a slot-table predictor kept in a small class
// depends on olft_pkg and the order_lifecycle_fill_tracker rtl
module tb_order_lifecycle_fill_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOOK_SLOTS   = olft_pkg::SLOTS_DEFAULT;
    localparam int RANDOM_ITEMS = 1740;
    localparam int LONG_HOLD    = 400;    // receiver hold-off that backs the block up
    localparam int DRAIN_CYCLES = 64;     // well past the command latency

    // opcodes the block does not decode, both must answer with a state error
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // one result item, field by field as it leaves the block
    typedef struct packed {
        logic [7:0]  slot;
        logic [1:0]  err;
        logic [2:0]  status;
        logic [31:0] filled;
        logic [31:0] remaining;
        logic [31:0] avg_price;
        logic [47:0] last_update;
    } fill_report_t;

    // predicted order table plus the queue of results still owed by the block
    class order_book_model;
        logic [2:0]   status    [BOOK_SLOTS];
        logic [31:0]  total     [BOOK_SLOTS];
        logic [31:0]  filled    [BOOK_SLOTS];
        logic [63:0]  notional  [BOOK_SLOTS];
        logic [47:0]  placed_at [BOOK_SLOTS];
        logic [47:0] touched_at [BOOK_SLOTS];
        fill_report_t expected_results[$];
        int unsigned  mismatches;

        function new();
            foreach (status[i])
            begin
                status[i]     = olft_pkg::ST_CREATED;
                total[i]      = '0;
                filled[i]     = '0;
                notional[i]   = '0;
                placed_at[i]  = '0;
                touched_at[i] = '0;
            end
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // apply one accepted command and queue the result it must produce
        function void note_command(input logic [2:0] op, input logic [7:0] slot_in,
                                   input logic [31:0] qty, input logic [31:0] px,
                                   input logic [47:0] stamp);
            int unsigned  idx;
            logic [2:0]   st;
            logic [31:0]  open_qty;
            logic [1:0]   err;
            logic [63:0]  quotient;
            fill_report_t rep;

            idx      = slot_in % BOOK_SLOTS;
            st       = status[idx];
            open_qty = total[idx] - filled[idx];
            err      = olft_pkg::ERR_OK;

            case (op)
                olft_pkg::OP_CREATE:
                begin
                    // overwrites the slot whatever it held
                    if (qty == '0)
                        err = olft_pkg::ERR_ZERO;
                    else
                    begin
                        status[idx]     = olft_pkg::ST_CREATED;
                        total[idx]      = qty;
                        filled[idx]     = '0;
                        notional[idx]   = '0;
                        placed_at[idx]  = '0;
                        touched_at[idx] = stamp;
                    end
                end
                olft_pkg::OP_SUBMIT:
                begin
                    if (st != olft_pkg::ST_CREATED)
                        err = olft_pkg::ERR_STATE;
                    else if (total[idx] == '0)
                        err = olft_pkg::ERR_ZERO;
                    else
                    begin
                        status[idx]     = olft_pkg::ST_SUBMITTED;
                        placed_at[idx]  = stamp;
                        touched_at[idx] = stamp;
                    end
                end
                olft_pkg::OP_CANCEL, olft_pkg::OP_EXPIRE:
                begin
                    if (st != olft_pkg::ST_SUBMITTED && st != olft_pkg::ST_PARTIAL)
                        err = olft_pkg::ERR_STATE;
                    else
                    begin
                        status[idx]     = (op == olft_pkg::OP_CANCEL) ? olft_pkg::ST_CANCELLED
                                                                      : olft_pkg::ST_EXPIRED;
                        touched_at[idx] = stamp;
                    end
                end
                olft_pkg::OP_REJECT:
                begin
                    if (st != olft_pkg::ST_CREATED && st != olft_pkg::ST_SUBMITTED)
                        err = olft_pkg::ERR_STATE;
                    else
                    begin
                        status[idx]     = olft_pkg::ST_REJECTED;
                        touched_at[idx] = stamp;
                    end
                end
                olft_pkg::OP_FILL:
                begin
                    // zero check wins over state, state over overfill
                    if (qty == '0 || px == '0)
                        err = olft_pkg::ERR_ZERO;
                    else if (st != olft_pkg::ST_SUBMITTED && st != olft_pkg::ST_PARTIAL)
                        err = olft_pkg::ERR_STATE;
                    else if (qty > open_qty)
                        err = olft_pkg::ERR_OVERFILL;
                    else
                    begin
                        filled[idx]     = filled[idx] + qty;
                        notional[idx]   = notional[idx] + {32'd0, qty} * {32'd0, px};
                        status[idx]     = (qty == open_qty) ? olft_pkg::ST_FILLED
                                                            : olft_pkg::ST_PARTIAL;
                        touched_at[idx] = stamp;
                    end
                end
                default:
                begin
                    err = olft_pkg::ERR_STATE;
                end
            endcase

            quotient = '0;
            if (filled[idx] != '0)
                quotient = notional[idx] / {32'd0, filled[idx]};

            rep.slot        = slot_in;
            rep.err         = err;
            rep.status      = status[idx];
            rep.filled      = filled[idx];
            rep.remaining   = total[idx] - filled[idx];
            rep.avg_price   = quotient[31:0];
            rep.last_update = touched_at[idx];
            expected_results.push_back(rep);
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            $display("mismatch: %s", what);
        endtask

        // compare one accepted result with the oldest prediction
        task check_result(input fill_report_t got);
            fill_report_t want;

            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result for slot %0d with nothing expected", got.slot));
                return;
            end
            want = expected_results.pop_front();
            if (got.slot !== want.slot)
                report_mismatch($sformatf("slot_out %0d, want %0d", got.slot, want.slot));
            if (got.err !== want.err)
                report_mismatch($sformatf("slot %0d error_code %0d, want %0d",
                                          want.slot, got.err, want.err));
            if (got.status !== want.status)
                report_mismatch($sformatf("slot %0d status_out %0d, want %0d",
                                          want.slot, got.status, want.status));
            if (got.filled !== want.filled)
                report_mismatch($sformatf("slot %0d filled_out %0h, want %0h",
                                          want.slot, got.filled, want.filled));
            if (got.remaining !== want.remaining)
                report_mismatch($sformatf("slot %0d remaining_out %0h, want %0h",
                                          want.slot, got.remaining, want.remaining));
            if (got.avg_price !== want.avg_price)
                report_mismatch($sformatf("slot %0d average_price_out %0h, want %0h",
                                          want.slot, got.avg_price, want.avg_price));
            if (got.last_update !== want.last_update)
                report_mismatch($sformatf("slot %0d last_update_out %0h, want %0h",
                                          want.slot, got.last_update, want.last_update));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [2:0]  opcode;
    logic [7:0]  slot;
    logic [31:0] amount;
    logic [31:0] price;
    logic [47:0] event_time;
    logic        res_valid;
    logic        res_stall;
    logic [7:0]  slot_out;
    logic [1:0]  error_code;
    logic [2:0]  status_out;
    logic [31:0] filled_out;
    logic [31:0] remaining_out;
    logic [31:0] average_price_out;
    logic [47:0] last_update_out;

    order_book_model book = new();

    // idle rates in percent, changed per phase by the stimulus process
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // nonzero asks the receiver for a long hold-off, its length taken from this value
    int unsigned hold_request = 0;

    // slots that most random commands go to, so orders live through whole lifecycles
    logic [7:0] hot_slots [8];

    order_lifecycle_fill_tracker DUT (.*);

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run (about 2 ms even with heavy stalls)
    initial
    begin
        #(10_000_000);
        $display("tb: failure");
        $finish;
    end

    // offer one command and hold it until the block takes it; random idle cycles
    // go in front so gaps land on every phase of the block's work
    task automatic send_command(input logic [2:0] op, input logic [7:0] idx,
                                input logic [31:0] qty, input logic [31:0] px,
                                input logic [47:0] stamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        opcode     <= op;
        slot       <= idx;
        amount     <= qty;
        price      <= px;
        event_time <= stamp;
        // cmd_stall read right after the edge is the value the block saw at it
        do
            @(posedge clk);
        while (cmd_stall);
        book.note_command(op, idx, qty, px, stamp);
    endtask

    // pick a command that mostly follows a sensible lifecycle for the chosen slot,
    // using the predicted status; the rest is noise with any opcode and zero fields
    task automatic next_command(output logic [2:0] op, output logic [7:0] idx,
                                output logic [31:0] qty, output logic [31:0] px,
                                output logic [47:0] stamp);
        logic [2:0]  st;
        logic [31:0] open_qty;
        int unsigned roll;

        idx = ($urandom_range(99) < 70) ? hot_slots[$urandom_range(7)]
                                        : 8'($urandom_range(255));
        st       = book.status[idx];
        open_qty = book.total[idx] - book.filled[idx];
        stamp    = 48'({$urandom, $urandom});
        px       = ($urandom_range(9) < 6) ? 32'($urandom_range(5000, 1)) : $urandom;

        // order sizes: mostly small, plenty of full-width ones, now and then the maximum
        roll = $urandom_range(9);
        if (roll < 5)
            qty = 32'($urandom_range(1000, 1));
        else if (roll == 9)
            qty = 32'hFFFF_FFFF;
        else
            qty = $urandom;

        roll = $urandom_range(99);
        if (roll < 15)
        begin
            // noise: any opcode, spare ones included, and zero amounts or prices
            op = 3'($urandom_range(7));
            if ($urandom_range(3) == 0)
                qty = '0;
            if ($urandom_range(3) == 0)
                px = '0;
        end
        else if (st == olft_pkg::ST_CREATED)
        begin
            if (book.total[idx] == '0 || roll > 94)
                op = olft_pkg::OP_CREATE;
            else if (roll < 85)
                op = olft_pkg::OP_SUBMIT;
            else
                op = olft_pkg::OP_REJECT;
        end
        else if (st == olft_pkg::ST_SUBMITTED || st == olft_pkg::ST_PARTIAL)
        begin
            if (roll < 72)
            begin
                // fills: the exact rest, small slices, or any legal size
                op = olft_pkg::OP_FILL;
                case ($urandom_range(2))
                    0: qty = open_qty;
                    1: qty = 32'($urandom_range((open_qty > 50) ? 50 : open_qty, 1));
                    default: qty = 32'($urandom_range(open_qty, 1));
                endcase
            end
            else if (roll < 80)
            begin
                // overfill by a little
                op  = olft_pkg::OP_FILL;
                qty = (open_qty > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF
                                                 : open_qty + 32'($urandom_range(3, 1));
            end
            else if (roll < 87)
                op = olft_pkg::OP_CANCEL;
            else if (roll < 94)
                op = olft_pkg::OP_EXPIRE;
            else
                op = olft_pkg::OP_REJECT;
        end
        else
        begin
            // finished orders: mostly recreated, otherwise poked with a late command
            if (roll < 85)
                op = olft_pkg::OP_CREATE;
            else
                op = 3'($urandom_range(5));
        end
    endtask

    task automatic run_random(input int unsigned count);
        logic [2:0]  op;
        logic [7:0]  idx;
        logic [31:0] qty;
        logic [31:0] px;
        logic [47:0] stamp;

        foreach (hot_slots[i])
            hot_slots[i] = 8'($urandom_range(255));
        repeat (count)
        begin
            next_command(op, idx, qty, px, stamp);
            send_command(op, idx, qty, px, stamp);
        end
    endtask

    // result side: take items when not stalling, check them, then choose the
    // next stall value; a long hold-off, when asked for, is counted here
    initial
    begin
        fill_report_t got;
        int unsigned  hold_left;

        hold_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                got.slot        = slot_out;
                got.err         = error_code;
                got.status      = status_out;
                got.filled      = filled_out;
                got.remaining   = remaining_out;
                got.avg_price   = average_price_out;
                got.last_update = last_update_out;
                book.check_result(got);
            end
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // stimulus
    initial
    begin
        rst_n      <= 1'b0;
        cmd_valid  <= 1'b0;
        opcode     <= olft_pkg::OP_CREATE;
        slot       <= '0;
        amount     <= '0;
        price      <= '0;
        event_time <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // the clearing pass after reset holds cmd_stall high; send_command waits it out

        // sender rarely idles, receiver often stalls
        send_idle_pct = 12;
        recv_idle_pct = 64;

        // untouched slot: submit finds no quantity, fills with a zero field,
        // cancel from created, reject of a never-created slot
        send_command(olft_pkg::OP_SUBMIT, 8'd0, 32'd5, 32'd1, 48'd1);
        send_command(olft_pkg::OP_FILL,   8'd0, 32'd0, 32'd7, 48'd2);
        send_command(olft_pkg::OP_FILL,   8'd0, 32'd7, 32'd0, 48'd3);
        send_command(olft_pkg::OP_CANCEL, 8'd0, 32'd0, 32'd0, 48'd4);
        send_command(olft_pkg::OP_REJECT, 8'd1, 32'd0, 32'd0, 48'd5);

        // largest order, a near-largest fill at the largest price: average at the top of its
        // range, then an overfill, the exact closing fill and an expire on a filled order
        send_command(olft_pkg::OP_CREATE, 8'd2, 32'hFFFF_FFFF, 32'd0, 48'hFFFF_FFFF_FFFF);
        send_command(olft_pkg::OP_SUBMIT, 8'd2, 32'd0, 32'd0, 48'h8000_0000_0000);
        send_command(olft_pkg::OP_FILL,   8'd2, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 48'd1);
        send_command(olft_pkg::OP_FILL,   8'd2, 32'd2, 32'd9, 48'd2);
        send_command(olft_pkg::OP_FILL,   8'd2, 32'd1, 32'hFFFF_FFFF, 48'h0000_FFFF_0000);
        send_command(olft_pkg::OP_EXPIRE, 8'd2, 32'd0, 32'd0, 48'd7);

        // top slot: zero create, smallest order, double submit, expire, late reject
        send_command(olft_pkg::OP_CREATE, 8'd255, 32'd0, 32'd0, 48'd8);
        send_command(olft_pkg::OP_CREATE, 8'd255, 32'd1, 32'd0, 48'd0);
        send_command(olft_pkg::OP_SUBMIT, 8'd255, 32'd0, 32'd0, 48'd9);
        send_command(olft_pkg::OP_SUBMIT, 8'd255, 32'd0, 32'd0, 48'd10);
        send_command(olft_pkg::OP_EXPIRE, 8'd255, 32'd0, 32'd0, 48'd11);
        send_command(olft_pkg::OP_REJECT, 8'd255, 32'd0, 32'd0, 48'd12);

        // partial fill, reject refused while partial, cancel accepted
        send_command(olft_pkg::OP_CREATE, 8'd3, 32'd10, 32'd0, 48'd13);
        send_command(olft_pkg::OP_SUBMIT, 8'd3, 32'd0, 32'd0, 48'd14);
        send_command(olft_pkg::OP_FILL,   8'd3, 32'd4, 32'd3, 48'd15);
        send_command(olft_pkg::OP_REJECT, 8'd3, 32'd0, 32'd0, 48'd16);
        send_command(olft_pkg::OP_CANCEL, 8'd3, 32'd0, 32'd0, 48'd17);

        // spare opcodes, the first with every field high, then create over a filled order
        send_command(OP_SPARE_6, 8'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_command(OP_SPARE_7, 8'd170, 32'hAAAA_AAAA, 32'h5555_5555, 48'hAAAA_5555_AAAA);
        send_command(olft_pkg::OP_CREATE, 8'd2, 32'd1, 32'd0, 48'd18);

        run_random(RANDOM_ITEMS / 3);

        // sender often idles, receiver rarely stalls
        send_idle_pct = 64;
        recv_idle_pct = 12;
        run_random(RANDOM_ITEMS / 3);

        // no idling on either side; start with a long receiver hold-off while the
        // sender keeps offering, so the block backs up and stalls its input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = LONG_HOLD;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        cmd_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
